// ----- rtl/lpp_pkg.sv -----
// ---------------------------------------------------------------------------
// lpp_pkg
// Shared widths, register codes, reset values and types for the lidar
// point to pixel projection pipeline.
// ---------------------------------------------------------------------------
package lpp_pkg;

   // image coordinate width
   localparam int DIM_BITS  = 13;
   // camera coordinate, 22 fraction bits, signed
   localparam int COORD_W   = 34;
   // projection numerator f*a + c*z, signed
   localparam int NUM_W     = 51;
   // numerator magnitude and divider remainder
   localparam int MAG_W     = 52;
   // denominator z*16, unsigned (only used for z > 0)
   localparam int DEN_W     = 37;
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROT0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE  = 3'd6;

   // reset values
   localparam logic [47:0] ROT0_RST   = 48'd16384;
   localparam logic [47:0] ROT1_RST   = 48'd1073741824;
   localparam logic [47:0] ROT2_RST   = 48'd70368744177664;
   localparam logic [47:0] TRANS_RST  = 48'd0;
   localparam logic [31:0] FOCAL_RST  = 32'd1162364232;
   localparam logic [31:0] CENTER_RST = 32'd503851016;
   localparam logic [2*DIM_BITS-1:0] IMAGE_RST = (2*DIM_BITS)'(7865600);

   typedef enum logic [1:0] {
      OUT_INSIDE  = 2'd0,
      OUT_BEHIND  = 2'd1,
      OUT_OUTSIDE = 2'd2
   } outcome_type;

   // unpacked configuration
   typedef struct packed {
      logic signed [2:0][2:0][15:0] rot;   // [row][col]
      logic signed [2:0][15:0]      trans;
      logic [1:0][15:0]             focal;  // 0: fx, 1: fy
      logic [1:0][15:0]             center; // 0: cx, 1: cy
      logic [DIM_BITS-1:0]          cols;
      logic [DIM_BITS-1:0]          rows;
   } cfg_type;

   // divider result per coordinate
   typedef struct packed {
      logic                neg;
      logic                ovf;
      logic [DIM_BITS-1:0] quo;
   } quot_type;

endpackage

// ----- rtl/lpp_req_if.sv -----
// ---------------------------------------------------------------------------
// lpp_req_if
// Request channel: one lidar point in signed Q8.8 metres.
// ---------------------------------------------------------------------------
interface lpp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;

   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// ----- rtl/lpp_rsp_if.sv -----
// ---------------------------------------------------------------------------
// lpp_rsp_if
// Response channel: outcome code and pixel position.
// ---------------------------------------------------------------------------
interface lpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  outcome;
   logic [12:0] pixel_column;
   logic [12:0] pixel_row;

   modport source (output valid, outcome, pixel_column, pixel_row, input ready);
   modport sink   (input valid, outcome, pixel_column, pixel_row, output ready);
endinterface

// ----- rtl/lpp_xform.sv -----
// ---------------------------------------------------------------------------
// lpp_xform
// Rigid transform, two stages: nine rotation products, then row sums
// plus the translation. Camera coordinates carry 22 fraction bits.
// ---------------------------------------------------------------------------
module lpp_xform import lpp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [2:0][15:0]   point,
   input  cfg_type                   cfg,
   output logic                      out_valid,
   output logic signed [COORD_W-1:0] coord [3]
);

   logic signed [31:0]        prod_ff  [3][3];
   logic signed [31:0]        prod_in  [3][3];
   logic signed [15:0]        trans_ff [3];
   logic signed [COORD_W-1:0] coord_ff [3];
   logic signed [COORD_W-1:0] coord_in [3];
   logic                      v1_ff, v2_ff;

   // rotation products, lane selects of packed arrays are unsigned
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(cfg.rot[r][c]) * $signed(point[c]);
         end
      end
   end

   // row sums plus translation scaled to 22 fraction bits
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         coord_in[r] = COORD_W'(prod_ff[r][0]) + COORD_W'(prod_ff[r][1])
                     + COORD_W'(prod_ff[r][2])
                     + COORD_W'($signed({trans_ff[r], 14'd0}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         coord_ff <= coord_in;
         for (int r = 0; r < 3; r++) begin
            trans_ff[r] <= cfg.trans[r];
         end
      end
   end

   assign out_valid = v2_ff;
   assign coord     = coord_ff;

endmodule

// ----- rtl/lpp_ratio.sv -----
// ---------------------------------------------------------------------------
// lpp_ratio
// Builds numerator f*a + c*z and denominator z*16 for both image axes,
// three stages: products, sum, magnitude and sign.
// ---------------------------------------------------------------------------
module lpp_ratio import lpp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] coord [3],
   input  cfg_type                   cfg,
   output logic                      out_valid,
   output logic                      out_behind,
   output logic [MAG_W-1:0]          mag [2],
   output logic                      neg [2],
   output logic [DEN_W-1:0]          den
);

   logic signed [NUM_W-1:0] fa_ff  [2];
   logic signed [NUM_W-1:0] cz_ff  [2];
   logic signed [NUM_W-1:0] fa_in  [2];
   logic signed [NUM_W-1:0] cz_in  [2];
   logic signed [NUM_W-1:0] num_ff [2];
   logic [MAG_W-1:0]        mag_ff [2];
   logic [MAG_W-1:0]        mag_in [2];
   logic                    neg_ff [2];
   logic [DEN_W-1:0]        den3_ff, den4_ff, den5_ff;
   logic [2:0]              valid_ff;
   logic [2:0]              behind_ff;

   // stage 3 products
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         fa_in[l] = NUM_W'($signed({1'b0, cfg.focal[l]})) * NUM_W'(coord[l]);
         cz_in[l] = NUM_W'($signed({1'b0, cfg.center[l]})) * NUM_W'(coord[2]);
      end
   end

   // stage 5 magnitude
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = num_ff[l][NUM_W-1] ? -MAG_W'(num_ff[l]) : MAG_W'(num_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fa_ff     <= fa_in;
         cz_ff     <= cz_in;
         den3_ff   <= {coord[2][DEN_W-5:0], 4'd0};
         behind_ff <= {behind_ff[1:0], (coord[2][COORD_W-1] || coord[2] == '0)};
         den4_ff   <= den3_ff;
         den5_ff   <= den4_ff;
         for (int l = 0; l < 2; l++) begin
            num_ff[l] <= fa_ff[l] + cz_ff[l];
            neg_ff[l] <= num_ff[l][NUM_W-1];
         end
         mag_ff <= mag_in;
      end
   end

   assign out_valid  = valid_ff[2];
   assign out_behind = behind_ff[2];
   assign mag        = mag_ff;
   assign neg        = neg_ff;
   assign den        = den5_ff;

endmodule

// ----- rtl/lpp_div.sv -----
// ---------------------------------------------------------------------------
// lpp_div
// Pipelined restoring divider for both axes: one overflow stage, then one
// quotient bit per stage, most significant first.
// ---------------------------------------------------------------------------
module lpp_div import lpp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic             in_behind,
   input  logic [MAG_W-1:0] mag [2],
   input  logic             neg [2],
   input  logic [DEN_W-1:0] den,
   output logic             out_valid,
   output logic             out_behind,
   output quot_type         quot [2]
);

   localparam int STAGES = DIM_BITS + 1;

   logic [STAGES-1:0]   valid_ff;
   logic [STAGES-1:0]   behind_ff;
   logic [DEN_W-1:0]    den_ff [STAGES];
   logic [MAG_W-1:0]    rem_ff [STAGES][2];
   logic [MAG_W-1:0]    rem_in [STAGES][2];
   quot_type            q_ff   [STAGES][2];
   quot_type            q_in   [STAGES][2];

   // overflow check and one quotient bit per stage
   always_comb begin
      logic [MAG_W-1:0] trial;
      logic             ge;
      for (int l = 0; l < 2; l++) begin
         trial          = MAG_W'(den) << DIM_BITS;
         q_in[0][l].neg = neg[l];
         q_in[0][l].ovf = mag[l] >= trial;
         q_in[0][l].quo = '0;
         rem_in[0][l]   = mag[l];
      end
      for (int s = 1; s < STAGES; s++) begin
         for (int l = 0; l < 2; l++) begin
            trial        = MAG_W'(den_ff[s-1]) << (DIM_BITS - s);
            ge           = rem_ff[s-1][l] >= trial;
            q_in[s][l]   = q_ff[s-1][l];
            rem_in[s][l] = ge ? rem_ff[s-1][l] - trial : rem_ff[s-1][l];
            q_in[s][l].quo[DIM_BITS-s] = ge;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         behind_ff <= {behind_ff[STAGES-2:0], in_behind};
         den_ff[0] <= den;
         for (int s = 1; s < STAGES; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_behind = behind_ff[STAGES-1];
   assign quot       = q_ff[STAGES-1];

endmodule

// ----- rtl/lidar_point_to_pixel_projection.sv -----
// ---------------------------------------------------------------------------
// lidar_point_to_pixel_projection
// Rigid transform of a lidar point into camera space and pinhole
// projection to a pixel, with behind-camera and bounds flags.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  req_chan | in        | point_x, point_y, point_z (signed Q8.8)
//  rsp_chan | out       | outcome, pixel_column, pixel_row
//  csr_*    | in        | write enable, register index, 48-bit data
//
//  one request per cycle unless the response is stalled; pipeline stages from
//  accept to response valid: 2 transform, 3 ratio, 14 divider, 1 classify,
//  1 output register; the divider stages set the depth, one quotient bit each
//  a stalled response holds the whole pipeline; req_chan.ready drops then
//  synchronous reset clears all valid bits and loads default registers
// ---------------------------------------------------------------------------
module lidar_point_to_pixel_projection import lpp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lpp_req_if.sink              req_chan,
   lpp_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   logic [47:0]           rot_ff [3];
   logic [47:0]           trans_ff;
   logic [31:0]           focal_ff, center_ff;
   logic [2*DIM_BITS-1:0] image_ff;
   cfg_type               cfg;
   logic                  en;

   logic                      xf_valid;
   logic signed [COORD_W-1:0] coord [3];
   logic                      ra_valid, ra_behind;
   logic [MAG_W-1:0]          mag [2];
   logic                      neg [2];
   logic [DEN_W-1:0]          den;
   logic                      dv_valid, dv_behind;
   quot_type                  quot [2];

   logic [DIM_BITS-1:0] pix_in [2];
   logic                out_in [2];
   outcome_type         outcome_in, outcome_ff;
   logic [DIM_BITS-1:0] col_ff, row_ff, col_in, row_in;
   logic                cls_valid_ff, rsp_valid_ff;
   outcome_type         rsp_outcome_ff;
   logic [DIM_BITS-1:0] rsp_col_ff, rsp_row_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT0_RST;
         rot_ff[1] <= ROT1_RST;
         rot_ff[2] <= ROT2_RST;
         trans_ff  <= TRANS_RST;
         focal_ff  <= FOCAL_RST;
         center_ff <= CENTER_RST;
         image_ff  <= IMAGE_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_ROT0:   rot_ff[0] <= csr_write_data;
            REG_ROT1:   rot_ff[1] <= csr_write_data;
            REG_ROT2:   rot_ff[2] <= csr_write_data;
            REG_TRANS:  trans_ff  <= csr_write_data;
            REG_FOCAL:  focal_ff  <= csr_write_data[31:0];
            REG_CENTER: center_ff <= csr_write_data[31:0];
            REG_IMAGE:  image_ff  <= csr_write_data[2*DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // unpack configuration fields
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cfg.rot[r] = rot_ff[r];
      end
      cfg.trans  = trans_ff;
      cfg.focal  = focal_ff;
      cfg.center = center_ff;
      cfg.cols   = image_ff[DIM_BITS-1:0];
      cfg.rows   = image_ff[2*DIM_BITS-1:DIM_BITS];
   end

   // whole pipeline advances unless the response is stalled
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   lpp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .point     ({req_chan.point_z, req_chan.point_y, req_chan.point_x}),
      .cfg       (cfg),
      .out_valid (xf_valid),
      .coord     (coord)
   );

   lpp_ratio u_ratio (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (xf_valid),
      .coord      (coord),
      .cfg        (cfg),
      .out_valid  (ra_valid),
      .out_behind (ra_behind),
      .mag        (mag),
      .neg        (neg),
      .den        (den)
   );

   lpp_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (ra_valid),
      .in_behind  (ra_behind),
      .mag        (mag),
      .neg        (neg),
      .den        (den),
      .out_valid  (dv_valid),
      .out_behind (dv_behind),
      .quot       (quot)
   );

   // saturate each axis and flag out of range values
   always_comb begin
      logic [DIM_BITS-1:0] lim;
      for (int l = 0; l < 2; l++) begin
         lim = (l == 0) ? cfg.cols : cfg.rows;
         if (quot[l].neg) begin
            pix_in[l] = '0;
            out_in[l] = quot[l].ovf || quot[l].quo != '0 || lim == '0;
         end else if (quot[l].ovf) begin
            pix_in[l] = '1;
            out_in[l] = 1'b1;
         end else begin
            pix_in[l] = quot[l].quo;
            out_in[l] = quot[l].quo >= lim;
         end
      end
      if (dv_behind) begin
         outcome_in = OUT_BEHIND;
         col_in     = '0;
         row_in     = '0;
      end else begin
         outcome_in = (out_in[0] || out_in[1]) ? OUT_OUTSIDE : OUT_INSIDE;
         col_in     = pix_in[0];
         row_in     = pix_in[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         cls_valid_ff <= dv_valid;
         rsp_valid_ff <= cls_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         outcome_ff     <= outcome_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         rsp_outcome_ff <= outcome_ff;
         rsp_col_ff     <= col_ff;
         rsp_row_ff     <= row_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.outcome      = rsp_outcome_ff;
   assign rsp_chan.pixel_column = rsp_col_ff;
   assign rsp_chan.pixel_row    = rsp_row_ff;

endmodule

// ----- rtl/lpp_checker.sv -----
// ---------------------------------------------------------------------------
// lpp_checker
// Port-level checks on the projection block, bound to the top level.
// ---------------------------------------------------------------------------
module lpp_checker import lpp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_outcome,
   input logic [12:0] rsp_column,
   input logic [12:0] rsp_row
);

   // a waiting response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome)
                                 && $stable(rsp_column) && $stable(rsp_row))
      else $error("response changed while stalled");

   // an empty output always takes requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // a stalled output stops intake
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken during stall");

   // behind-camera points report pixel zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_BEHIND |-> rsp_column == '0 && rsp_row == '0)
      else $error("behind-camera response with nonzero pixel");

endmodule

bind lidar_point_to_pixel_projection lpp_checker u_lpp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_outcome (rsp_chan.outcome),
   .rsp_column  (rsp_chan.pixel_column),
   .rsp_row     (rsp_chan.pixel_row)
);

// ----- tb/lidar_point_to_pixel_projection_tb.sv -----
// ---------------------------------------------------------------------------
// lidar_point_to_pixel_projection_tb
// Streams lidar points through the projection pipeline under random
// request gaps and response stalls, predicts each pixel result in exact
// integer arithmetic and compares every response in order.
// ---------------------------------------------------------------------------
module lidar_point_to_pixel_projection_tb;
   import lpp_pkg::*;

   typedef struct {
      outcome_type         outcome;
      logic [DIM_BITS-1:0] column;
      logic [DIM_BITS-1:0] row;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ROT0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   lpp_req_if req_chan ();
   lpp_rsp_if rsp_chan ();

   // shadow copy of the configuration
   logic [47:0] rot_row [3];
   logic [47:0] trans_xyz;
   logic [31:0] focal_pair;
   logic [31:0] center_pair;
   logic [25:0] image_dims;

   pixel_type pixel_queue [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  rsp_stalls  = 1'b1;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PIPE_LATENCY   = 21;

   lidar_point_to_pixel_projection dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // random gap length, mostly short
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // exact projection of one point into the camera image
   function automatic pixel_type project_point(logic signed [15:0] px,
                                               logic signed [15:0] py,
                                               logic signed [15:0] pz);
      pixel_type res;
      longint cam [3];
      longint pt [3];
      longint u, v, num, cols, rows;
      pt[0] = px; pt[1] = py; pt[2] = pz;
      for (int r = 0; r < 3; r++) begin
         cam[r] = longint'($signed(trans_xyz[16*r +: 16])) * 16384;
         for (int c = 0; c < 3; c++)
            cam[r] += longint'($signed(rot_row[r][16*c +: 16])) * pt[c];
      end
      if (cam[2] <= 0) begin
         res.outcome = OUT_BEHIND;
         res.column = '0;
         res.row = '0;
         return res;
      end
      num = longint'(focal_pair[15:0]) * cam[0] + longint'(center_pair[15:0]) * cam[2];
      u = num / (cam[2] * 16);
      num = longint'(focal_pair[31:16]) * cam[1] + longint'(center_pair[31:16]) * cam[2];
      v = num / (cam[2] * 16);
      cols = image_dims[DIM_BITS-1:0];
      rows = image_dims[2*DIM_BITS-1:DIM_BITS];
      res.outcome = (u >= 0 && u < cols && v >= 0 && v < rows) ? OUT_INSIDE : OUT_OUTSIDE;
      res.column = (u < 0) ? '0 : (u > 8191) ? 13'h1FFF : DIM_BITS'(u);
      res.row    = (v < 0) ? '0 : (v > 8191) ? 13'h1FFF : DIM_BITS'(v);
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // write one register, block is idle
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [47:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         REG_ROT0:   rot_row[0]  = data;
         REG_ROT1:   rot_row[1]  = data;
         REG_ROT2:   rot_row[2]  = data;
         REG_TRANS:  trans_xyz   = data;
         REG_FOCAL:  focal_pair  = data[31:0];
         REG_CENTER: center_pair = data[31:0];
         REG_IMAGE:  image_dims  = data[25:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // send one point request, valid stays up for a back-to-back request
   task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                             bit gaps = 1'b1);
      int gap;
      gap = gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.point_x <= px;
      req_chan.point_y <= py;
      req_chan.point_z <= pz;
      do @(posedge clock); while (!req_chan.ready);
      pixel_queue.push_back(project_point(px, py, pz));
   endtask

   // end the request burst and wait for every response
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] random_coord();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 4096)) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   // points at the reset calibration: axes, extremes, behind and outside; then altered registers
   task automatic test_directed();
      send_point(16'h0000, 16'h0000, 16'h0100);
      send_point(16'h0000, 16'h0000, 16'h0000);
      send_point(16'h0000, 16'h0000, 16'hFF00);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000, 16'h7FFF);
      send_point(16'h8000, 16'h8000, 16'h8000);
      send_point(16'h7FFF, 16'h0000, 16'h0001);
      send_point(16'h8000, 16'h7FFF, 16'h0001);
      send_point(16'h0100, 16'hFF00, 16'h0400);
      send_point(16'hFFFF, 16'hFFFF, 16'h7000);
      send_point(16'hFEE0, 16'hFEF0, 16'h0200);
      send_point(16'hFFFF, 16'h0000, 16'h7FFF);
      send_point(16'h5555, 16'hAAAA, 16'h1234);
      send_point(16'hAAAA, 16'h5555, 16'h4321);
      drain_pipeline();
      // slightly negative pixel, zero image size, register extremes
      write_register(REG_CENTER, 48'h0);
      send_point(16'hFFFF, 16'hFFFF, 16'h0100);
      drain_pipeline();
      write_register(REG_IMAGE, 48'h0);
      send_point(16'h0000, 16'h0000, 16'h0100);
      drain_pipeline();
      write_register(REG_FOCAL, 48'hFFFF_FFFF_FFFF);
      write_register(REG_CENTER, 48'hFFFF_FFFF_FFFF);
      write_register(REG_IMAGE, 48'hFFFF_FFFF_FFFF);
      write_register(REG_TRANS, 48'h7FFF_8000_7FFF);
      write_register(REG_ROT0, 48'h7FFF_8000_7FFF);
      write_register(REG_ROT1, 48'h8000_7FFF_8000);
      write_register(REG_ROT2, 48'h7FFF_7FFF_7FFF);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h0001, 16'h7FFF);
      send_point(16'h0000, 16'h0000, 16'h0000);
      // index beyond the register map is ignored
      drain_pipeline();
      write_register(3'd7, 48'hFFFF_FFFF_FFFF);
      send_point(16'h0100, 16'h0200, 16'h0300);
      drain_pipeline();
   endtask

   // random calibrations, mostly around a plausible camera, plus random points
   task automatic test_random_setups();
      for (int phase = 0; phase < 12; phase++) begin
         if (phase % 4 == 3) begin
            write_register(REG_ROT0, {$urandom, $urandom});
            write_register(REG_ROT1, {$urandom, $urandom});
            write_register(REG_ROT2, {$urandom, $urandom});
            write_register(REG_TRANS, {$urandom, $urandom});
            write_register(REG_FOCAL, $urandom);
            write_register(REG_CENTER, $urandom);
            write_register(REG_IMAGE, $urandom);
         end else begin
            write_register(REG_ROT0, ROT0_RST);
            write_register(REG_ROT1, ROT1_RST);
            write_register(REG_ROT2, ROT2_RST);
            write_register(REG_TRANS, {16'($urandom_range(0, 1024)), 16'($urandom),
                                       16'($urandom)} & 48'h0FFF_00FF_00FF);
            write_register(REG_FOCAL, {16'($urandom_range(64, 40000)),
                                       16'($urandom_range(64, 40000))});
            write_register(REG_CENTER, {16'($urandom_range(0, 20000)),
                                        16'($urandom_range(0, 20000))});
            write_register(REG_IMAGE, {13'($urandom_range(0, 2000)),
                                       13'($urandom_range(0, 2000))});
         end
         rsp_stalls = (phase % 3 != 1);
         for (int n = 0; n < 52; n++)
            send_point(random_coord(), random_coord(), random_coord(), phase % 3 != 2);
         drain_pipeline();
      end
   endtask

   // response side: random stalls, check against oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pixel_queue.size() == 0) begin
               $display("response with no pending request");
               error_count++;
            end else begin
               pixel_type want;
               want = pixel_queue.pop_front();
               if (rsp_chan.outcome !== want.outcome)
                  report_mismatch("outcome", rsp_chan.outcome, want.outcome);
               if (rsp_chan.pixel_column !== want.column)
                  report_mismatch("pixel_column", rsp_chan.pixel_column, want.column);
               if (rsp_chan.pixel_row !== want.row)
                  report_mismatch("pixel_row", rsp_chan.pixel_row, want.row);
            end
         end
         rsp_chan.ready <= !rsp_stalls || ($urandom_range(0, 99) < 70) ||
                           ($urandom_range(0, 99) < 50);
      end
   end

   // watchdog on cycles without any accepted handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("lidar_point_to_pixel_projection test failed");
         $finish;
      end
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.point_z = '0;
      rot_row[0]  = ROT0_RST;
      rot_row[1]  = ROT1_RST;
      rot_row[2]  = ROT2_RST;
      trans_xyz   = TRANS_RST;
      focal_pair  = FOCAL_RST;
      center_pair = CENTER_RST;
      image_dims  = IMAGE_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_setups();
      if (error_count == 0)
         $display("lidar_point_to_pixel_projection test passed");
      else
         $display("lidar_point_to_pixel_projection test failed");
      $finish;
   end

endmodule
